[rtl/core/gtg_pkg.sv]
// shared types, constants and the arctangent table of the go-to-goal controller
`default_nettype none

package gtg_pkg;

  // datapath widths
  localparam int XY_W       = 28;  // cordic x/y: 17 bit offset << 8 plus gain headroom
  localparam int Z_W        = 34;  // cordic angle in 2^-30 rad, covers +-pi plus table sum
  localparam int ATAN_W     = 30;
  localparam int ATAN_IDX_W = 5;

  // cordic gain 1/K in 2^-30 units, and pi in 2^-30 rad
  localparam logic [29:0]          CORDIC_K = 30'd652032874;
  localparam logic signed [Z_W-1:0] PI_Z    = 34'sd3373259426;

  typedef enum logic [1:0] {
    REQ_POSE   = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_TOL    = 3'd0,
    CFG_MIN    = 3'd1,
    CFG_MAX    = 3'd2,
    CFG_FAR    = 3'd3,
    CFG_KP_LIN = 3'd4,
    CFG_KP_ANG = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_DIST,
    S_ANG,
    S_LIN
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
  } cmd_t;

  // atan(2^-i) in 2^-30 rad
  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gtg_cordic.sv]
// iterative cordic vectoring unit, one micro-rotation per cycle
`default_nettype none

module gtg_cordic import gtg_pkg::*; #(
  parameter int ITERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [XY_W-1:0] x_init,
  input  logic signed [XY_W-1:0] y_init,
  input  logic signed [Z_W-1:0]  z_init,
  output logic                  done,
  output logic signed [XY_W-1:0] x_res,
  output logic signed [Z_W-1:0]  z_res
);

  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ITERS - 1);

  logic                   run;
  logic [CNT_W-1:0]       cnt;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  step_z;

  always_comb begin
    xs     = x >>> cnt;
    ys     = y >>> cnt;
    step_z = $signed({{(Z_W - ATAN_W){1'b0}}, atan_q30(ATAN_IDX_W'(cnt))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_init;
      y <= y_init;
      z <= z_init;
    end else if (run) begin
      // rotate toward y = 0
      if (y[XY_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_z;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_z;
      end
    end
  end

  assign x_res = x;
  assign z_res = z;

endmodule

`default_nettype wire

[rtl/core/go_to_goal_p_controller.sv]
// go-to-goal proportional controller top level: state, sequencer, shared multiplier
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_t  (pose, target or tick)
//  cmd     | out       | cmd_valid/cmd_ready | cmd_t  (linear and angular speed)
//  cfg     | in        | cfg_we              | cfg_idx, cfg_data
//
// pose and target beats are stored as they are taken; a tick's command beat
// is valid once it has passed through the cordic loop
// that does one micro-rotation per cycle, followed by three multiplies on one
// shared multiplier. req_ready is high only while the sequencer is idle.
// a finished command waits in the output register; a new tick may start while
// it waits and stalls before its own result only if that beat is still not taken.
// rst is synchronous and restores the register defaults and a zero pose and target.
`default_nettype none

module go_to_goal_p_controller import gtg_pkg::*; #(
  parameter int CORDIC_ITERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  localparam int MA_W     = XY_W;
  localparam int MB_W     = 31;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int DIST_W   = 18;
  localparam int DIST_LSB = 38;

  localparam logic signed [PROD_W-1:0] DIST_HALF = PROD_W'(64'd1 << 37);
  localparam logic signed [PROD_W-1:0] ANG_HALF  = PROD_W'(64'd1 << 15);
  localparam logic signed [PROD_W-1:0] LIN_HALF  = PROD_W'(64'd1 << 11);

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [15:0] r;
    if (v[PROD_W-1:15] == '0 || v[PROD_W-1:15] == '1) begin
      r = v[15:0];
    end else if (v[PROD_W-1]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7FFF;
    end
    return r;
  endfunction

  // configuration
  logic [14:0] tolerance_dist;
  logic [14:0] min_dist;
  logic [14:0] max_dist;
  logic [14:0] far_substitute;
  logic [15:0] kp_linear;
  logic [15:0] kp_angular;

  // stored pose and target
  logic signed [15:0] robot_x;
  logic signed [15:0] robot_y;
  logic signed [15:0] robot_heading;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;

  state_t state;
  state_t state_next;
  logic   req_fire;
  logic   cordic_start;
  logic   cordic_done;
  logic   out_free;

  logic signed [16:0]     dx;
  logic signed [16:0]     dy;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  logic signed [Z_W-1:0]  z0;
  logic                   zero_now;
  logic                   zero_vec;

  logic signed [XY_W-1:0] cx;
  logic signed [Z_W-1:0]  cz;
  logic signed [XY_W-1:0] cx_pos;
  logic signed [Z_W-1:0]  z_sum;
  logic signed [17:0]     alpha;
  logic signed [17:0]     neg_err_next;
  logic signed [17:0]     neg_err;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_en;

  logic signed [PROD_W-1:0] d_sum;
  logic [DIST_W-1:0]        d_raw;
  logic [DIST_W-1:0]        clamp_dist_next;
  logic [DIST_W-1:0]        clamp_dist;
  logic [DIST_W-1:0]        tol_x;
  logic [DIST_W-1:0]        min_x;
  logic [DIST_W-1:0]        max_x;
  logic [DIST_W-1:0]        far_x;
  logic signed [PROD_W-1:0] a_sum;
  logic signed [PROD_W-1:0] l_sum;
  logic signed [15:0]       ang_next;
  logic signed [15:0]       ang;
  logic signed [15:0]       lin_next;

  assign req_fire = req_valid && req_ready;
  assign out_free = !cmd_valid || cmd_ready;

  // ---------------------------------------------------------------- sequencer

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cordic_start = 1'b0;
    prod_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && req.req_type == REQ_TICK) begin
          cordic_start = 1'b1;
          state_next   = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          prod_en    = 1'b1;
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        prod_en    = 1'b1;
        state_next = S_ANG;
      end
      S_ANG: begin
        prod_en    = 1'b1;
        state_next = S_LIN;
      end
      S_LIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_dist <= 15'd13;
      min_dist       <= 15'd256;
      max_dist       <= 15'd1280;
      far_substitute <= 15'd256;
      kp_linear      <= 16'd1229;
      kp_angular     <= 16'd20480;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TOL:    tolerance_dist <= cfg_data[14:0];
        CFG_MIN:    min_dist       <= cfg_data[14:0];
        CFG_MAX:    max_dist       <= cfg_data[14:0];
        CFG_FAR:    far_substitute <= cfg_data[14:0];
        CFG_KP_LIN: kp_linear      <= cfg_data;
        CFG_KP_ANG: kp_angular     <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x       <= '0;
      robot_y       <= '0;
      robot_heading <= '0;
      target_x      <= '0;
      target_y      <= '0;
    end else if (req_fire) begin
      if (req.req_type == REQ_POSE) begin
        robot_x       <= req.pos_x;
        robot_y       <= req.pos_y;
        robot_heading <= req.heading;
      end else if (req.req_type == REQ_TARGET) begin
        target_x <= req.goal_x;
        target_y <= req.goal_y;
      end
    end
  end

  // ---------------------------------------------------------------- cordic setup

  always_comb begin
    dx       = $signed({target_x[15], target_x}) - $signed({robot_x[15], robot_x});
    dy       = $signed({target_y[15], target_y}) - $signed({robot_y[15], robot_y});
    x_sh     = $signed({{(XY_W - 25){dx[16]}}, dx, 8'b0});
    y_sh     = $signed({{(XY_W - 25){dy[16]}}, dy, 8'b0});
    zero_now = (dx == '0) && (dy == '0);
    // left half plane: flip the vector and start from +-pi
    if (dx[16]) begin
      x0 = -x_sh;
      y0 = -y_sh;
      z0 = dy[16] ? -PI_Z : PI_Z;
    end else begin
      x0 = x_sh;
      y0 = y_sh;
      z0 = '0;
    end
  end

  gtg_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cordic_start),
    .x_init (x0),
    .y_init (y0),
    .z_init (z0),
    .done   (cordic_done),
    .x_res  (cx),
    .z_res  (cz)
  );

  always_comb begin
    cx_pos = cx[XY_W-1] ? '0 : cx;
    z_sum  = cz + Z_W'(34'sd131072);
    alpha  = {{2{z_sum[Z_W-1]}}, z_sum[Z_W-1:18]};
    // robot on target: bearing taken as zero
    if (zero_vec) begin
      neg_err_next = -{{2{robot_heading[15]}}, robot_heading};
    end else begin
      neg_err_next = alpha - {{2{robot_heading[15]}}, robot_heading};
    end
  end

  // ---------------------------------------------------------------- shared multiplier

  always_comb begin
    unique case (state)
      S_CORDIC: begin
        mul_a = cx_pos;
        mul_b = $signed({1'b0, CORDIC_K});
      end
      S_DIST: begin
        mul_a = {{(MA_W - 18){neg_err[17]}}, neg_err};
        mul_b = $signed({{(MB_W - 16){1'b0}}, kp_angular});
      end
      default: begin
        mul_a = $signed({{(MA_W - DIST_W){1'b0}}, clamp_dist});
        mul_b = $signed({{(MB_W - 16){1'b0}}, kp_linear});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // ---------------------------------------------------------------- post processing

  always_comb begin
    tol_x = {{(DIST_W - 15){1'b0}}, tolerance_dist};
    min_x = {{(DIST_W - 15){1'b0}}, min_dist};
    max_x = {{(DIST_W - 15){1'b0}}, max_dist};
    far_x = {{(DIST_W - 15){1'b0}}, far_substitute};
    d_sum = prod + DIST_HALF;
    d_raw = d_sum[DIST_LSB +: DIST_W];
    // clamp steps run in order, each sees the previous result
    clamp_dist_next = zero_vec ? '0 : d_raw;
    if (clamp_dist_next <= tol_x) begin
      clamp_dist_next = '0;
    end
    if (clamp_dist_next > tol_x && clamp_dist_next < min_x) begin
      clamp_dist_next = min_x;
    end
    if (clamp_dist_next > max_x) begin
      clamp_dist_next = far_x;
    end
    a_sum    = prod + ANG_HALF;
    ang_next = sat16(a_sum >>> 16);
    l_sum    = prod + LIN_HALF;
    lin_next = sat16(l_sum >>> 12);
  end

  always_ff @(posedge clk) begin
    if (cordic_start) begin
      zero_vec <= zero_now;
    end
    if (state == S_CORDIC && cordic_done) begin
      neg_err <= neg_err_next;
    end
    if (state == S_DIST) begin
      clamp_dist <= clamp_dist_next;
    end
    if (state == S_ANG) begin
      ang <= ang_next;
    end
  end

  // ---------------------------------------------------------------- output register

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (state == S_LIN && out_free) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LIN && out_free) begin
      cmd.linear_speed  <= lin_next;
      cmd.angular_speed <= ang;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gtg_checker.sv]
// port-level checks for the go-to-goal controller, bound to the top level
`default_nettype none

module gtg_checker import gtg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input req_t        req,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input cmd_t        cmd
);

  logic tick_fire;
  assign tick_fire = req_valid && req_ready && req.req_type == REQ_TICK;

  // no command beat right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("cmd_valid high after reset");

  // a stalled command beat holds
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command beat dropped or changed while stalled");

  // a tick occupies the block: no beat taken in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> !req_ready)
    else $error("request accepted right after a tick");

  // a new command never shows up in the cycle after a tick is taken
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> !$rose(cmd_valid))
    else $error("command appeared too early after a tick");

  // a command is produced only while requests are held off
  a_cmd_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_valid) |-> !$past(req_ready))
    else $error("command produced while idle");

endmodule

bind go_to_goal_p_controller gtg_checker u_gtg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd)
);

`default_nettype wire
